/* design/idll_pkg.sv */
// Package for the indexed doubly linked list core: function codes, status codes
// and the word passed from the front end to the back end. No dependencies.
package idll_pkg;

  typedef enum logic [3:0] {
    FN_FRONT      = 4'd0,
    FN_BACK       = 4'd1,
    FN_AFTER_SLOT = 4'd2,
    FN_BEFORE_SLOT = 4'd3,
    FN_AFTER_KEY  = 4'd4,
    FN_BEFORE_KEY = 4'd5,
    FN_ERASE      = 4'd6,
    FN_FIND       = 4'd7,
    FN_READ       = 4'd8
  } func_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // One classified command as queued between front and back end.
  typedef struct packed {
    logic [3:0]  func;
    logic [31:0] value;
    logic [31:0] key;
    logic [5:0]  slot;
  } cmd_t;

endpackage

/* design/idll_front.sv */
// Front end of the linked list core: accepts input words into a short queue.
// Depends on idll_pkg.
module idll_front #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  idll_pkg::cmd_t  in_cmd,
  output logic            q_valid,
  input  logic            q_ready,
  output idll_pkg::cmd_t  q_cmd
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  idll_pkg::cmd_t    mem [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [AW:0]       count;
  logic              push;
  logic              pop;

  assign in_ready = (count != (AW+1)'(DEPTH));
  assign q_valid  = (count != '0);
  assign q_cmd    = mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= (AW+1)'(DEPTH))
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !q_valid)
    else $error("empty queue presents a word");
  assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> count == $past(count) - 1'b1)
    else $error("queue count lost a pop");
endmodule

/* design/idll_back.sv */
// Back end of the linked list core: the link tables, the chain walker and the
// relink sequencer. Depends on idll_pkg.
module idll_back #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_ready,
  input  idll_pkg::cmd_t  q_cmd,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      status,
  output logic [5:0]      slot_out,
  output logic [31:0]     value_out
);
  localparam int IW = $clog2(CAPACITY);

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_RDA    = 11'b00000000100,
    S_WAITA  = 11'b00000001000,
    S_SRCH   = 11'b00000010000,
    S_SWAIT  = 11'b00000100000,
    S_PREV   = 11'b00001000000,
    S_PWAIT  = 11'b00010000000,
    S_LINK   = 11'b00100000000,
    S_LINK2  = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  state_t state;

  // Memories, one port each, registered read.
  logic [VALUE_BITS-1:0] vals  [CAPACITY];
  logic [IW-1:0]         nexts [CAPACITY];
  logic [IW-1:0]         prevs [CAPACITY];
  logic [CAPACITY-1:0]   in_use;

  logic [IW-1:0]         v_ra, n_ra, p_ra;
  logic [VALUE_BITS-1:0] v_rd;
  logic [IW-1:0]         n_rd, p_rd;
  logic                  n_we, p_we, v_we;
  logic [IW-1:0]         n_wa, p_wa, v_wa;
  logic [IW-1:0]         n_wd, p_wd;
  logic [VALUE_BITS-1:0] v_wd;

  always_ff @(posedge clk) begin
    if (v_we) vals[v_wa] <= v_wd;
    v_rd <= vals[v_ra];
  end
  always_ff @(posedge clk) begin
    if (n_we) nexts[n_wa] <= n_wd;
    n_rd <= nexts[n_ra];
  end
  always_ff @(posedge clk) begin
    if (p_we) prevs[p_wa] <= p_wd;
    p_rd <= prevs[p_ra];
  end

  idll_pkg::cmd_t        cmd;
  logic [IW-1:0]         free_head;
  logic [IW-1:0]         clr;
  logic [IW-1:0]         cur;
  logic [IW:0]           steps;
  logic [IW-1:0]         p, q, n, res;
  logic [1:0]            sub;
  logic [VALUE_BITS-1:0] val_w, key_w, target;
  logic [1:0]            st_r;
  logic [5:0]            so_r;
  logic [31:0]           vo_r;
  logic                  slot_in;
  logic [IW-1:0]         slot_ix;

  function automatic logic [VALUE_BITS-1:0] widen(input logic [31:0] x);
    logic [63:0] w;
    w = {{32{x[31]}}, x};
    return w[VALUE_BITS-1:0];
  endfunction

  assign val_w   = widen(cmd.value);
  assign key_w   = widen(cmd.key);
  assign target  = (cmd.func == idll_pkg::FN_ERASE || cmd.func == idll_pkg::FN_FIND)
                   ? val_w : key_w;
  assign slot_in = (32'(cmd.slot) < CAPACITY);
  assign slot_ix = IW'(cmd.slot);

  assign q_ready   = (state == S_IDLE);
  assign out_valid = (state == S_DONE);
  assign status    = st_r;
  assign slot_out  = so_r;
  assign value_out = vo_r;

  // Memory port control. Link walks read next and value of the same slot.
  always_comb begin
    v_ra = cur; n_ra = cur; p_ra = cur;
    n_we = 1'b0; p_we = 1'b0; v_we = 1'b0;
    n_wa = '0; p_wa = '0; v_wa = '0;
    n_wd = '0; p_wd = '0; v_wd = val_w;
    unique case (state)
      S_CLEAR: begin
        n_we = 1'b1; p_we = 1'b1; n_wa = clr; p_wa = clr;
        n_wd = (clr == '0 || clr == IW'(CAPACITY-1)) ? '0 : clr + 1'b1;
      end
      S_LINK: begin
        unique case (sub)
          2'd0: begin
            n_we = 1'b1; n_wa = q; n_wd = n;
            p_we = 1'b1; p_wa = q; p_wd = p;
            v_we = 1'b1; v_wa = q;
          end
          default: begin
            n_we = 1'b1; n_wa = p; n_wd = q;
            p_we = 1'b1; p_wa = n; p_wd = q;
          end
        endcase
      end
      S_LINK2: begin
        // Erase: res between p and n.
        unique case (sub)
          2'd0: begin
            n_we = 1'b1; n_wa = p; n_wd = n;
            p_we = 1'b1; p_wa = n; p_wd = p;
          end
          default: begin
            n_we = 1'b1; n_wa = res; n_wd = free_head;
            p_we = 1'b1; p_wa = res; p_wd = '0;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) cmd <= q_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      free_head <= IW'(1);
      in_use    <= '0;
      cur <= '0; steps <= '0; p <= '0; q <= '0; n <= '0; res <= '0; sub <= '0;
      st_r <= idll_pkg::ST_OK; so_r <= '0; vo_r <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == IW'(CAPACITY-1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            st_r <= idll_pkg::ST_OK; so_r <= '0; vo_r <= '0;
            state <= S_RDA;
          end
        end
        S_RDA: begin
          // Choose what to read: the given slot, or the sentinel to start.
          sub <= '0;
          unique case (cmd.func) inside
            idll_pkg::FN_FRONT, idll_pkg::FN_BACK: begin
              cur <= '0; state <= S_WAITA;
            end
            idll_pkg::FN_AFTER_SLOT, idll_pkg::FN_BEFORE_SLOT, idll_pkg::FN_READ: begin
              if (!slot_in || (slot_ix != '0 && !in_use[slot_ix]) ||
                  (cmd.func == idll_pkg::FN_READ && slot_ix == '0)) begin
                st_r <= idll_pkg::ST_BAD; state <= S_DONE;
              end else begin
                cur <= slot_ix; state <= S_WAITA;
              end
            end
            idll_pkg::FN_AFTER_KEY, idll_pkg::FN_BEFORE_KEY,
            idll_pkg::FN_ERASE, idll_pkg::FN_FIND: begin
              cur <= '0; steps <= '0; state <= S_SRCH;
            end
            default: state <= S_DONE;
          endcase
        end
        S_WAITA: begin
          // Wait for the registered read of slot cur.
          if (sub == 2'd0) begin
            sub <= 2'd1;
          end else begin
            sub <= '0;
            if (cmd.func == idll_pkg::FN_READ) begin
              vo_r <= 32'(v_rd); state <= S_DONE;
            end else begin
              // Insert parent p, for "before" forms the predecessor of cur.
              if (cmd.func == idll_pkg::FN_BACK || cmd.func == idll_pkg::FN_BEFORE_SLOT)
                p <= p_rd;
              else
                p <= cur;
              state <= S_PREV;
            end
          end
        end
        S_SRCH: begin
          // Issue read of cur's next link; value of cur compared in S_SWAIT.
          state <= S_SWAIT; sub <= '0;
        end
        S_SWAIT: begin
          if (sub == 2'd0) begin
            sub <= 2'd1;
          end else begin
            if (cur != '0 && v_rd == target) begin
              res <= cur;
              if (cmd.func == idll_pkg::FN_FIND) begin
                so_r <= 6'(cur); state <= S_DONE;
              end else if (cmd.func == idll_pkg::FN_ERASE) begin
                p <= p_rd; n <= n_rd; sub <= '0; state <= S_LINK2;
              end else begin
                p <= (cmd.func == idll_pkg::FN_BEFORE_KEY) ? p_rd : cur;
                state <= S_PREV;
              end
            end else if ((cur != '0 || steps != '0) &&
                         (n_rd == '0 || steps == (IW+1)'(CAPACITY-1))) begin
              st_r <= idll_pkg::ST_MISS; state <= S_DONE;
            end else if (cur == '0 && steps == '0 && n_rd == '0) begin
              st_r <= idll_pkg::ST_MISS; state <= S_DONE;
            end else begin
              cur <= n_rd; steps <= steps + 1'b1; state <= S_SRCH;
            end
          end
        end
        S_PREV: begin
          // Full check, then read next of p and next of the free head.
          if (free_head == '0) begin
            st_r <= idll_pkg::ST_FULL; state <= S_DONE;
          end else begin
            q <= free_head; cur <= p; sub <= '0; state <= S_PWAIT;
          end
        end
        S_PWAIT: begin
          unique case (sub)
            2'd0: sub <= 2'd1;
            2'd1: begin n <= n_rd; cur <= q; sub <= 2'd2; end
            2'd2: sub <= 2'd3;
            default: begin
              free_head <= n_rd; sub <= '0; state <= S_LINK;
            end
          endcase
        end
        S_LINK: begin
          if (sub == 2'd0) begin
            sub <= 2'd1;
          end else begin
            in_use[q] <= 1'b1; so_r <= 6'(q); state <= S_DONE;
          end
        end
        S_LINK2: begin
          if (sub == 2'd0) begin
            sub <= 2'd1;
          end else begin
            in_use[res] <= 1'b0; free_head <= res; so_r <= 6'(res); state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && st_r != idll_pkg::ST_OK) |-> so_r == '0)
    else $error("failure reports a slot");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(so_r))
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (rst) !in_use[0])
    else $error("sentinel marked in use");
endmodule

/* design/indexed_doubly_linked_list_core.sv */
// Indexed doubly linked list core over a table of CAPACITY slots with a free
// chain. Depends on idll_pkg, idll_front and idll_back.
// After reset a clearing pass over every slot rebuilds the link tables; up to
// two words wait in the front queue meanwhile. Each word yields one result.
// Value searches walk the chain one link read at a time, paced by the registered
// single read port of the link tables.
module indexed_doubly_linked_list_core #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  func,
  input  logic [31:0] value,
  input  logic [31:0] key,
  input  logic [5:0]  slot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [5:0]  slot_out,
  output logic [31:0] value_out
);
  idll_pkg::cmd_t in_cmd, q_cmd;
  logic           q_valid, q_ready;

  assign in_cmd = '{func: func, value: value, key: key, slot: slot};

  idll_front #(.DEPTH(2)) u_front (
    .clk, .rst, .in_valid, .in_ready, .in_cmd,
    .q_valid, .q_ready, .q_cmd
  );

  idll_back #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd,
    .out_valid, .out_ready, .status, .slot_out, .value_out
  );
endmodule
